// ===== hw/rtl/nar_pkg.sv =====
// Shared types and constants for the neighbor advertisement receive parser.
// Used by every module under hw/rtl; depends on nothing.
package nar_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 2048;
  // The byte counter has to hold MAX_MESSAGE_BYTES itself once a message overflows.
  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
  // Option end arithmetic: start plus up to 255 units of 8 bytes.
  localparam int unsigned END_W = (CNT_W + 1 > 12) ? CNT_W + 1 : 12;

  localparam int unsigned OPT_BASE   = 24;
  localparam int unsigned UNIT_BYTES = 8;
  localparam int unsigned TYPE_IDX   = 0;
  localparam int unsigned FLAGS_IDX  = 4;
  localparam int unsigned MIN_BYTES  = 4;
  localparam int unsigned ADDR_FIRST = 2;
  localparam int unsigned ADDR_LAST  = 7;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVERT_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_OPTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLICITED_MASK = 2'd2;

  localparam logic [7:0] ADVERT_TYPE_RST    = 8'd136;
  localparam logic [7:0] WANTED_OPTION_RST  = 8'd1;
  localparam logic [7:0] SOLICITED_MASK_RST = 8'd1 << 1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_CSUM   = 3'd2,
    ST_NOT_ADVERT = 3'd3,
    ST_UNSOLICIT  = 3'd4,
    ST_BAD_OPTION = 3'd5,
    ST_NO_ADDRESS = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] advert_type;
    logic [7:0] wanted_option;
    logic [7:0] solicited_mask;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [47:0] link_address;
  } result_t;

endpackage

// ===== hw/rtl/nar_cfg_regs.sv =====
// Configuration registers of the parser, written through a plain write port.
// Depends on nar_pkg.
module nar_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nar_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i,
  output nar_pkg::cfg_t                 cfg_o
);

  nar_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        nar_pkg::CFG_ADVERT_TYPE:    cfg_d.advert_type    = cfg_wdata_i;
        nar_pkg::CFG_WANTED_OPTION:  cfg_d.wanted_option  = cfg_wdata_i;
        nar_pkg::CFG_SOLICITED_MASK: cfg_d.solicited_mask = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.advert_type    <= nar_pkg::ADVERT_TYPE_RST;
      cfg_q.wanted_option  <= nar_pkg::WANTED_OPTION_RST;
      cfg_q.solicited_mask <= nar_pkg::SOLICITED_MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/nar_byte_proc.sv =====
// Per-byte message state: checksum, header capture, option walk and final verdict.
// Depends on nar_pkg; driven by the registered input stage of the top level.
module nar_byte_proc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       msg_byte_i,
  input  logic             last_byte_i,
  input  nar_pkg::cfg_t    cfg_i,
  output nar_pkg::result_t result_o
);

  localparam int unsigned CW = nar_pkg::CNT_W;
  localparam int unsigned EW = nar_pkg::END_W;

  typedef enum logic [2:0] {
    PH_SEARCHING  = 3'd0,
    PH_HAVE_KIND  = 3'd1,
    PH_COLLECTING = 3'd2,
    PH_ZERO_LEN   = 3'd3,
    PH_FOUND      = 3'd4
  } phase_e;

  logic [CW-1:0] count_q, count_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    pend_q, pend_d;
  logic [7:0]    mtype_q, mtype_d;
  logic [7:0]    flags_q, flags_d;
  logic [CW-1:0] start_q, start_d;
  logic [7:0]    units_q, units_d;
  logic [7:0]    kind_q, kind_d;
  phase_e        phase_q, phase_d;
  logic [47:0]   addr_q, addr_d;

  logic [15:0]   word;
  logic [16:0]   sum_raw;
  logic          do_add;
  logic [CW-1:0] offs;
  logic [EW-1:0] opt_end;
  logic          in_range;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    pend_d  = pend_q;
    mtype_d = mtype_q;
    flags_d = flags_q;
    start_d = start_q;
    units_d = units_q;
    kind_d  = kind_q;
    phase_d = phase_q;
    addr_d  = addr_q;

    in_range = count_q < CW'(nar_pkg::MAX_MESSAGE_BYTES);
    offs     = count_q - start_q;
    opt_end  = EW'(start_q) + EW'({units_q, 3'b000}) - EW'(1);
    word     = 16'd0;
    do_add   = 1'b0;
    sum_raw  = 17'd0;

    if (in_range) begin
      // Even bytes are the high half of a word; an odd-length tail pads with zero.
      if (!count_q[0]) begin
        if (last_byte_i) begin
          word   = {msg_byte_i, 8'd0};
          do_add = 1'b1;
        end else begin
          pend_d = msg_byte_i;
        end
      end else begin
        word   = {pend_q, msg_byte_i};
        do_add = 1'b1;
      end
      if (do_add) begin
        sum_raw = {1'b0, sum_q} + {1'b0, word};
        sum_d   = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end

      if (count_q == CW'(nar_pkg::TYPE_IDX))  mtype_d = msg_byte_i;
      if (count_q == CW'(nar_pkg::FLAGS_IDX)) flags_d = msg_byte_i;

      case (phase_q)
        PH_SEARCHING: begin
          if (count_q == start_q) begin
            kind_d  = msg_byte_i;
            phase_d = PH_HAVE_KIND;
          end
        end
        PH_HAVE_KIND: begin
          units_d = msg_byte_i;
          phase_d = (msg_byte_i == 8'd0) ? PH_ZERO_LEN : PH_COLLECTING;
        end
        PH_COLLECTING: begin
          if (offs >= CW'(nar_pkg::ADDR_FIRST) && offs <= CW'(nar_pkg::ADDR_LAST)) begin
            addr_d = {addr_q[39:0], msg_byte_i};
          end
          if (EW'(count_q) == opt_end) begin
            if (kind_q == cfg_i.wanted_option) begin
              phase_d = PH_FOUND;
            end else begin
              start_d = count_q + CW'(1);
              phase_d = PH_SEARCHING;
            end
          end
        end
        default: ;
      endcase

      count_d = count_q + CW'(1);
    end
  end

  // Verdict over the state as it stands after this byte.
  always_comb begin
    result_o.link_address = 48'd0;
    if (count_d < CW'(nar_pkg::MIN_BYTES)) begin
      result_o.status = nar_pkg::ST_SHORT;
    end else if (sum_d != 16'hFFFF) begin
      result_o.status = nar_pkg::ST_BAD_CSUM;
    end else if (mtype_d != cfg_i.advert_type) begin
      result_o.status = nar_pkg::ST_NOT_ADVERT;
    end else if (count_d < CW'(nar_pkg::OPT_BASE)) begin
      result_o.status = nar_pkg::ST_SHORT;
    end else if ((flags_d & cfg_i.solicited_mask) == 8'd0) begin
      result_o.status = nar_pkg::ST_UNSOLICIT;
    end else if (phase_d == PH_FOUND) begin
      result_o.status       = nar_pkg::ST_OK;
      result_o.link_address = addr_d;
    end else if (phase_d == PH_SEARCHING) begin
      result_o.status = nar_pkg::ST_NO_ADDRESS;
    end else if (EW'(count_d) >= EW'(start_d) + EW'(nar_pkg::UNIT_BYTES)) begin
      result_o.status = nar_pkg::ST_BAD_OPTION;
    end else begin
      result_o.status = nar_pkg::ST_NO_ADDRESS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      pend_q  <= '0;
      mtype_q <= '0;
      flags_q <= '0;
      start_q <= CW'(nar_pkg::OPT_BASE);
      units_q <= '0;
      kind_q  <= '0;
      phase_q <= PH_SEARCHING;
      addr_q  <= '0;
    end else if (en_i) begin
      if (last_byte_i) begin
        // The message is finished: start the next one from a clean slate.
        count_q <= '0;
        sum_q   <= '0;
        pend_q  <= '0;
        mtype_q <= '0;
        flags_q <= '0;
        start_q <= CW'(nar_pkg::OPT_BASE);
        units_q <= '0;
        kind_q  <= '0;
        phase_q <= PH_SEARCHING;
        addr_q  <= '0;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        pend_q  <= pend_d;
        mtype_q <= mtype_d;
        flags_q <= flags_d;
        start_q <= start_d;
        units_q <= units_d;
        kind_q  <= kind_d;
        phase_q <= phase_d;
        addr_q  <= addr_d;
      end
    end
  end

endmodule

// ===== hw/rtl/neighbor_advert_rx_parser_core.sv =====
// Neighbor advertisement receive parser: one message byte per transaction.
// The last byte passes the byte stage register; its result is then loaded into the
// output register, which offers it until its own transaction completes.
// Throughput: one byte per cycle; the byte stage stalls only while a finished
// result waits in the output register and a last byte needs that register.
// Reset: asynchronous, active low; the configuration registers return to their defaults and
// all message state is cleared.
module neighbor_advert_rx_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    msg_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [47:0]                   link_address_o,
  input  logic                          cfg_we_i,
  input  logic [nar_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i
);

  nar_pkg::cfg_t    cfg;
  nar_pkg::result_t result;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       out_free;
  logic       out_load;
  logic       in_take;

  logic             out_valid_q;
  nar_pkg::result_t out_q;

  nar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign out_load   = s1_adv && s1_last_q;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  nar_byte_proc u_proc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s1_adv),
    .msg_byte_i  (s1_byte_q),
    .last_byte_i (s1_last_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= msg_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign link_address_o = out_q.link_address;

  // The byte stage only holds back while it owns a byte.
  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty byte stage");

  // A last byte blocked at the byte stage means the output is full and stalled.
  a_last_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && !s1_adv) |-> (out_valid_q && out_stall_i))
    else $error("last byte held without a blocked result");

  // Only a good verdict carries an address.
  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != nar_pkg::ST_OK) |-> (link_address_o == 48'd0))
    else $error("address reported with a failing status");

  // A loaded result is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result loaded but not offered");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for neighbor_advert_rx_parser_core: a byte-level parse model
// predicts each status and link address. Depends on nar_pkg and the core RTL only.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned ITEM_TARGET = 600;

  typedef enum logic [2:0] {WALK_SEEK, WALK_KIND, WALK_GRAB, WALK_ZERO, WALK_DONE} walk_e;
  typedef enum logic [1:0] {CSUM_RAW, CSUM_GOOD, CSUM_BAD} csum_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    msg_byte_i = 8'h00;
  logic                          last_byte_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [2:0]                    status_o;
  logic [47:0]                   link_address_o;
  logic                          cfg_we_i = 1'b0;
  logic [nar_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]                    cfg_wdata_i = 8'h00;

  neighbor_advert_rx_parser_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .msg_byte_i     (msg_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .link_address_o (link_address_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copies and parse state of the prediction.
  nar_pkg::cfg_t cfg_model;
  int unsigned   adv_count;
  logic [15:0]   adv_sum;
  logic [7:0]    adv_hi;
  logic [7:0]    adv_type;
  logic [7:0]    adv_flags;
  int unsigned   opt_start;
  logic [7:0]    opt_units;
  logic [7:0]    opt_kind;
  walk_e         walk;
  logic [47:0]   opt_addr;

  nar_pkg::result_t parse_results_due[$];
  logic [8:0]       byte_feed[$];
  logic [7:0]       frame[$];

  logic        in_stall_seen = 1'b0;
  bit          calm_link = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned messages_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 1;
  int unsigned status_tally[8];

  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_parse();
    adv_count = 0;
    adv_sum   = 16'h0000;
    adv_hi    = 8'h00;
    adv_type  = 8'h00;
    adv_flags = 8'h00;
    opt_start = nar_pkg::OPT_BASE;
    opt_units = 8'h00;
    opt_kind  = 8'h00;
    walk      = WALK_SEEK;
    opt_addr  = 48'h0;
  endtask

  // Advances the parse by one accepted byte and queues the verdict on a final byte.
  task automatic take_byte(input logic [7:0] b, input logic last);
    int unsigned idx, remain, offs, opt_end;
    nar_pkg::result_t r;
    idx = adv_count;
    if (idx < nar_pkg::MAX_MESSAGE_BYTES) begin
      if (idx % 2 == 0) begin
        if (last) adv_sum = ones_add(adv_sum, {b, 8'h00});
        else adv_hi = b;
      end else begin
        adv_sum = ones_add(adv_sum, {adv_hi, b});
      end
      if (idx == nar_pkg::TYPE_IDX) adv_type = b;
      if (idx == nar_pkg::FLAGS_IDX) adv_flags = b;
      case (walk)
        WALK_SEEK: begin
          if (idx == opt_start) begin
            opt_kind = b;
            walk = WALK_KIND;
          end
        end
        WALK_KIND: begin
          opt_units = b;
          walk = (b == 8'h00) ? WALK_ZERO : WALK_GRAB;
        end
        WALK_GRAB: begin
          offs = idx - opt_start;
          opt_end = opt_start + opt_units * nar_pkg::UNIT_BYTES - 1;
          if (offs >= nar_pkg::ADDR_FIRST && offs <= nar_pkg::ADDR_LAST)
            opt_addr = {opt_addr[39:0], b};
          if (idx == opt_end) begin
            if (opt_kind == cfg_model.wanted_option) begin
              walk = WALK_DONE;
            end else begin
              opt_start = idx + 1;
              walk = WALK_SEEK;
            end
          end
        end
        default: ;
      endcase
      adv_count = idx + 1;
    end
    if (last) begin
      remain = (adv_count >= opt_start) ? adv_count - opt_start : 0;
      r.link_address = 48'h0;
      if (adv_count < nar_pkg::MIN_BYTES) r.status = nar_pkg::ST_SHORT;
      else if (adv_sum != 16'hFFFF) r.status = nar_pkg::ST_BAD_CSUM;
      else if (adv_type != cfg_model.advert_type) r.status = nar_pkg::ST_NOT_ADVERT;
      else if (adv_count < nar_pkg::OPT_BASE) r.status = nar_pkg::ST_SHORT;
      else if ((adv_flags & cfg_model.solicited_mask) == 8'h00)
        r.status = nar_pkg::ST_UNSOLICIT;
      else if (walk == WALK_DONE) begin
        r.status = nar_pkg::ST_OK;
        r.link_address = opt_addr;
      end else if (walk == WALK_SEEK) r.status = nar_pkg::ST_NO_ADDRESS;
      else r.status = (remain >= nar_pkg::UNIT_BYTES) ? nar_pkg::ST_BAD_OPTION
                                                      : nar_pkg::ST_NO_ADDRESS;
      parse_results_due.push_back(r);
      clear_parse();
    end
  endtask

  // Input side: stall is sampled mid-cycle, so it is settled before the edge it governs.
  always @(negedge clk_i) in_stall_seen = in_stall_o;

  always @(posedge clk_i) begin : byte_driver
    logic [8:0] next_byte;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_seen) begin
        take_byte(msg_byte_i, last_byte_i);
        bytes_accepted++;
      end
      if (!(in_valid_i && in_stall_seen)) begin
        if (byte_feed.size() != 0 && (calm_link || $urandom_range(99) >= 23)) begin
          next_byte = byte_feed.pop_front();
          in_valid_i  <= 1'b1;
          msg_byte_i  <= next_byte[7:0];
          last_byte_i <= next_byte[8];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= !calm_link && ($urandom_range(99) < 23);

  // Output side: a transaction completes at the next edge when valid and not stalled.
  always @(negedge clk_i) begin : result_check
    nar_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parse_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: status %0d link address %012h",
                   cycle_count, status_o, link_address_o);
      end else begin
        want = parse_results_due.pop_front();
        results_checked++;
        status_tally[want.status]++;
        if (status_o !== want.status || link_address_o !== want.link_address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: status exp %0d got %0d, %s %012h got %012h",
                     cycle_count, want.status, status_o, "address exp",
                     want.link_address, link_address_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, parse_results_due.size());
      $display("** neighbor_advert_rx_parser_core: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (byte_feed.size() >= 4) @(posedge clk_i);
    byte_feed.push_back({last, b});
  endtask

  // Waits until every queued byte is taken and every verdict has come back.
  task automatic wait_idle(input int unsigned tail);
    do @(negedge clk_i);
    while (byte_feed.size() != 0 || in_valid_i || parse_results_due.size() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [nar_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      nar_pkg::CFG_ADVERT_TYPE:    cfg_model.advert_type = val;
      nar_pkg::CFG_WANTED_OPTION:  cfg_model.wanted_option = val;
      nar_pkg::CFG_SOLICITED_MASK: cfg_model.solicited_mask = val;
      default: ;
    endcase
  endtask

  task automatic add_filler(input int unsigned n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  task automatic begin_frame(input logic [7:0] kind, input logic [7:0] flags);
    frame.delete();
    frame.push_back(kind);
    frame.push_back(8'($urandom));
    frame.push_back(8'h00);
    frame.push_back(8'h00);
    frame.push_back(flags);
    add_filler(nar_pkg::OPT_BASE - 5);
  endtask

  task automatic add_option(input logic [7:0] kind, input logic [7:0] units,
                            input logic [47:0] addr);
    frame.push_back(kind);
    frame.push_back(units);
    for (int k = 5; k >= 0; k--) frame.push_back(addr[8*k +: 8]);
    if (units > 1) add_filler((units - 1) * nar_pkg::UNIT_BYTES);
  endtask

  task automatic trim_frame(input int unsigned drop);
    repeat (drop) if (frame.size() > 1) frame.delete(frame.size() - 1);
  endtask

  function automatic logic [15:0] frame_sum();
    int unsigned n;
    logic [15:0] s;
    n = (frame.size() < nar_pkg::MAX_MESSAGE_BYTES) ? frame.size()
                                                    : nar_pkg::MAX_MESSAGE_BYTES;
    s = 16'h0000;
    for (int unsigned i = 0; i < n; i += 2)
      s = ones_add(s, {frame[i], (i + 1 < n) ? frame[i + 1] : 8'h00});
    return s;
  endfunction

  task automatic send_frame(input csum_e mode);
    logic [15:0] s;
    if (frame.size() >= 4 && mode != CSUM_RAW) begin
      frame[2] = 8'h00;
      frame[3] = 8'h00;
      s = ~frame_sum();
      frame[2] = s[15:8];
      frame[3] = s[7:0];
      if (mode == CSUM_BAD) frame[3] = frame[3] ^ 8'($urandom_range(1, 255));
    end
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    messages_sent++;
  endtask

  function automatic logic [47:0] random_addr();
    logic [47:0] a;
    a[47:32] = 16'($urandom);
    a[31:0]  = $urandom;
    return a;
  endfunction

  // Mostly well-formed adverts with random content; the rest is noise or damaged.
  task automatic random_frame();
    int unsigned pick, n_opts;
    logic [7:0] kind, flags, units;
    pick = $urandom_range(99);
    if (pick < 10) begin
      frame.delete();
      add_filler($urandom_range(1, 40));
      send_frame(CSUM_RAW);
    end else begin
      kind = ($urandom_range(99) < 92) ? cfg_model.advert_type : 8'($urandom);
      flags = 8'($urandom);
      if ($urandom_range(99) < 85) flags = flags | cfg_model.solicited_mask;
      else flags = flags & ~cfg_model.solicited_mask;
      begin_frame(kind, flags);
      n_opts = $urandom_range(0, 3);
      repeat (n_opts) begin
        pick = $urandom_range(99);
        units = (pick < 8) ? 8'd0 : (pick < 83) ? 8'd1 : 8'($urandom_range(2, 3));
        add_option(($urandom_range(99) < 40) ? cfg_model.wanted_option : 8'($urandom),
                   units, random_addr());
      end
      if ($urandom_range(99) < 30) add_filler($urandom_range(1, 12));
      if ($urandom_range(99) < 15) trim_frame($urandom_range(1, 12));
      send_frame(($urandom_range(99) < 90) ? CSUM_GOOD : CSUM_BAD);
    end
  endtask

  task automatic test_basic_adverts();
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd1, 48'hFFFF_FFFF_FFFF);
    send_frame(CSUM_GOOD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST, nar_pkg::SOLICITED_MASK_RST);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd1, 48'h0);
    send_frame(CSUM_GOOD);
    // A foreign option is skipped over before the wanted one is found.
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'h42);
    add_option(8'd2, 8'd2, random_addr());
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd1, random_addr());
    send_frame(CSUM_GOOD);
  endtask

  task automatic test_short_and_order();
    frame.delete();
    frame.push_back(nar_pkg::ADVERT_TYPE_RST);
    send_frame(CSUM_RAW);
    frame.delete();
    add_filler(3);
    send_frame(CSUM_RAW);
    frame.delete();
    frame.push_back(nar_pkg::ADVERT_TYPE_RST);
    add_filler(3);
    send_frame(CSUM_GOOD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    trim_frame(1);
    send_frame(CSUM_GOOD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd1, random_addr());
    send_frame(CSUM_BAD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST - 8'd1, 8'hFF);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd1, random_addr());
    send_frame(CSUM_GOOD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST, ~nar_pkg::SOLICITED_MASK_RST);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd1, random_addr());
    send_frame(CSUM_GOOD);
  endtask

  task automatic test_option_faults();
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    send_frame(CSUM_GOOD);
    // Fewer than eight bytes left after the header.
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    add_filler(5);
    send_frame(CSUM_GOOD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd0, random_addr());
    send_frame(CSUM_GOOD);
    // Option claims three units but the message ends after one.
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    add_option(nar_pkg::WANTED_OPTION_RST, 8'd3, random_addr());
    trim_frame(16);
    send_frame(CSUM_GOOD);
    begin_frame(nar_pkg::ADVERT_TYPE_RST, 8'hFF);
    add_option(8'd9, 8'd1, random_addr());
    send_frame(CSUM_GOOD);
  endtask

  task automatic apply_settings(input logic [7:0] advert, input logic [7:0] wanted,
                                input logic [7:0] mask);
    wait_idle(DRAIN_CYCLES);
    write_reg(nar_pkg::CFG_ADVERT_TYPE, advert);
    write_reg(nar_pkg::CFG_WANTED_OPTION, wanted);
    write_reg(nar_pkg::CFG_SOLICITED_MASK, mask);
    settings_used++;
  endtask

  task automatic test_register_settings();
    apply_settings(8'h00, 8'h00, 8'hFF);
    repeat (2) random_frame();
    apply_settings(8'hFF, 8'hFF, 8'h01);
    repeat (2) random_frame();
    apply_settings(8'($urandom), 8'($urandom), 8'h00);
    random_frame();
    apply_settings(8'($urandom), 8'($urandom), 8'h80);
    repeat (2) random_frame();
    apply_settings(nar_pkg::ADVERT_TYPE_RST, nar_pkg::WANTED_OPTION_RST,
                   nar_pkg::SOLICITED_MASK_RST);
  endtask

  // Random traffic with a calm stretch and one full pause, topping up to the byte budget.
  task automatic test_random_traffic();
    int unsigned n;
    n = 0;
    while (n < 4 || bytes_accepted < ITEM_TARGET) begin
      calm_link = (n >= 1 && n < 4);
      random_frame();
      n++;
      if (n == 2) wait_idle(0);
    end
    calm_link = 1'b0;
  endtask

  initial begin
    cfg_model.advert_type    = nar_pkg::ADVERT_TYPE_RST;
    cfg_model.wanted_option  = nar_pkg::WANTED_OPTION_RST;
    cfg_model.solicited_mask = nar_pkg::SOLICITED_MASK_RST;
    clear_parse();
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_adverts();
    test_short_and_order();
    test_option_faults();
    test_register_settings();
    test_random_traffic();
    wait_idle(DRAIN_CYCLES * 2);

    $display("Covered %0d bytes in %0d messages under %0d register settings, %0d checked.",
             bytes_accepted, messages_sent, settings_used, results_checked);
    $display("Statuses: ok %0d, short %0d, checksum %0d, type %0d, unsolicited %0d,",
             status_tally[nar_pkg::ST_OK], status_tally[nar_pkg::ST_SHORT],
             status_tally[nar_pkg::ST_BAD_CSUM], status_tally[nar_pkg::ST_NOT_ADVERT],
             status_tally[nar_pkg::ST_UNSOLICIT]);
    $display("  option %0d, no address %0d.",
             status_tally[nar_pkg::ST_BAD_OPTION], status_tally[nar_pkg::ST_NO_ADDRESS]);
    if (mismatches == 0) begin
      $display("** neighbor_advert_rx_parser_core: PASSED **");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("** neighbor_advert_rx_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
